/* rtl/core/qltu_pkg.sv */
package qltu_pkg;

  // Table geometry
  localparam int NUM_STATES  = 256;
  localparam int NUM_ACTIONS = 8;

  // Field widths
  localparam int OP_W       = 2;
  localparam int STATE_W    = 8;
  localparam int ACT_W      = 3;
  localparam int Q_W        = 32;
  localparam int FRAC_W     = 16;
  localparam int RAND_W     = 16;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Q memory geometry
  localparam int Q_DEPTH = NUM_STATES * NUM_ACTIONS;
  localparam int QADDR_W = STATE_W + ACT_W;

  // Arithmetic widths: difference, product, increment, new value
  localparam int DIFF_W = Q_W + 2;
  localparam int PROD_W = FRAC_W + 1 + DIFF_W;
  localparam int INC_W  = PROD_W - FRAC_W;
  localparam int NV_W   = INC_W + 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CHOOSE = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION_COUNT      = 2'd3;

  // Register reset values
  localparam logic [FRAC_W-1:0] LEARNING_RATE_RST     = 16'd6554;
  localparam logic [FRAC_W-1:0] DISCOUNT_RST          = 16'd58982;
  localparam logic [FRAC_W-1:0] EXPLORE_THRESHOLD_RST = 16'd6554;
  localparam logic [CNT_W-1:0]  ACTION_COUNT_RST      = 4'd8;

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic        [FRAC_W-1:0] coef_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [INC_W-1:0]  inc_t;
  typedef logic signed [NV_W-1:0]   nv_t;

  localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // Remainder unit control and status
  typedef struct packed {
    logic              start;
    logic [RAND_W-1:0] word;
    logic [CNT_W-1:0]  count;
  } mod_ctl_t;

  typedef struct packed {
    logic             done;
    logic [ACT_W-1:0] rem;
  } mod_sts_t;

endpackage

/* rtl/core/qltu_channels.sv */
// Request channel: one item per operation
interface qltu_req_if import qltu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [OP_W-1:0]    operation;
  logic        [STATE_W-1:0] state_index;
  logic        [ACT_W-1:0]   action_index;
  logic        [STATE_W-1:0] next_state_index;
  logic signed [Q_W-1:0]     reward_value;
  logic        [RAND_W-1:0]  explore_draw;
  logic        [RAND_W-1:0]  random_word;

  modport source (
    output valid, operation, state_index, action_index, next_state_index,
           reward_value, explore_draw, random_word,
    input  ready
  );
  modport sink (
    input  valid, operation, state_index, action_index, next_state_index,
           reward_value, explore_draw, random_word,
    output ready
  );
endinterface

// Response channel: one item per request
interface qltu_rsp_if import qltu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic        [ACT_W-1:0] chosen_action;
  logic signed [Q_W-1:0]   q_value;
  logic        [ACT_W-1:0] policy_action;
  logic                    saturated;

  modport source (
    output valid, chosen_action, q_value, policy_action, saturated,
    input  ready
  );
  modport sink (
    input  valid, chosen_action, q_value, policy_action, saturated,
    output ready
  );
endinterface

// Register write channel
interface qltu_cfg_if import qltu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/qltu_ram.sv */
// Single-port RAM, registered read
module qltu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/core/qltu_mod.sv */
// Remainder of a random word by the action count, four bits per cycle
module qltu_mod import qltu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mod_ctl_t ctl,
  output mod_sts_t sts
);

  localparam int BITS   = 4;
  localparam int STEPS  = RAND_W / BITS;
  localparam int STEP_W = $clog2(STEPS);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step_cnt;
  logic [RAND_W-1:0] shift;
  logic [ACT_W-1:0]  rem;
  logic [ACT_W-1:0]  rem_next;
  logic [CNT_W-1:0]  divisor;

  // Restoring remainder steps, MSB first; rem stays below divisor
  always_comb begin
    logic [CNT_W-1:0] r;
    logic [ACT_W-1:0] acc;
    acc = rem;
    for (int i = 0; i < BITS; i++) begin
      r = {acc, shift[RAND_W-1-i]};
      if (r >= divisor) begin
        r = r - divisor;
      end
      acc = r[ACT_W-1:0];
    end
    rem_next = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy     <= 1'b1;
        step_cnt <= '0;
        shift    <= ctl.word;
        rem      <= '0;
        divisor  <= ctl.count;
      end else if (busy) begin
        rem      <= rem_next;
        shift    <= {shift[RAND_W-BITS-1:0], BITS'(0)};
        step_cnt <= step_cnt + STEP_W'(1);
        if (step_cnt == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.done = done;
  assign sts.rem  = rem;

endmodule

/* rtl/core/qltu_mul.sv */
// Shared fraction multiplier: unsigned Q0.16 coefficient times signed operand
module qltu_mul import qltu_pkg::*; (
  input  logic  clk,
  input  coef_t coef,
  input  diff_t opnd,
  output prod_t prod
);

  always_ff @(posedge clk) begin
    prod <= prod_t'(signed'({1'b0, coef})) * prod_t'(opnd);
  end

endmodule

/* rtl/core/q_learning_table_update_unit.sv */
// Channel   Role   Handshake      Payload
// req       sink   valid/ready    operation, state, action, next state, reward, draws
// rsp       source valid/ready    chosen_action, q_value, policy_action, saturated
// cfg       sink   valid/ready    index, data (always ready)
//
// Sequence per request (n = actions in use, 1..8): a greedy choose or an
// update scans n entries of a row through the single-port Q memory, and an
// update then uses the multiplier twice; an explore choose runs the remainder
// unit. The unit passes through idle before the next request is taken.
// After reset a pass clears the Q and policy memories; req.ready
// stays low meanwhile. A waiting result in rsp does not block the next request.
module q_learning_table_update_unit import qltu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  qltu_req_if.sink   req,
  qltu_rsp_if.source rsp,
  qltu_cfg_if.sink   cfg
);

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_SCAN     = 4'd2;
  localparam logic [3:0] ST_SCAN_END = 4'd3;
  localparam logic [3:0] ST_MOD      = 4'd4;
  localparam logic [3:0] ST_CH_RD    = 4'd5;
  localparam logic [3:0] ST_CH_POL   = 4'd6;
  localparam logic [3:0] ST_UP_MUL1  = 4'd7;
  localparam logic [3:0] ST_UP_DIFF  = 4'd8;
  localparam logic [3:0] ST_UP_MUL2  = 4'd9;
  localparam logic [3:0] ST_UP_WB    = 4'd10;
  localparam logic [3:0] ST_RD_ISSUE = 4'd11;
  localparam logic [3:0] ST_RD_DATA  = 4'd12;
  localparam logic [3:0] ST_FINISH   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  // Configuration
  coef_t            learning_rate;
  coef_t            discount;
  coef_t            explore_threshold;
  logic [CNT_W-1:0] action_count;
  logic [CNT_W-1:0] n_use;

  // Latched request
  logic [OP_W-1:0]    op_r;
  logic [STATE_W-1:0] s_r;
  logic [ACT_W-1:0]   a_r;
  logic [STATE_W-1:0] ns_r;
  q_t                 reward_r;
  logic               explore_r;

  // Scan and arithmetic
  logic [QADDR_W-1:0] clr_cnt;
  logic [CNT_W-1:0]   scan_i;
  logic               cmp_vld;
  logic [ACT_W-1:0]   cmp_idx;
  q_t                 best;
  logic [ACT_W-1:0]   best_idx;
  q_t                 cur;
  diff_t              diff;
  q_t                 g;
  inc_t               inc;
  nv_t                nv_wide;
  q_t                 nv_sat;
  logic               sat_flag;
  coef_t              mul_coef;
  diff_t              mul_opnd;
  prod_t              prod;

  // Results
  logic [ACT_W-1:0] res_chosen;
  q_t               res_q;
  logic             res_sat;
  logic             out_valid;
  logic [ACT_W-1:0] out_chosen;
  q_t               out_q;
  logic [ACT_W-1:0] out_pol;
  logic             out_sat;

  // Memory ports
  logic               q_we;
  logic               q_re;
  logic [QADDR_W-1:0] q_addr;
  q_t                 q_wdata;
  q_t                 q_rd;
  logic               p_we;
  logic               p_re;
  logic [STATE_W-1:0] p_addr;
  logic [ACT_W-1:0]   p_wdata;
  logic [ACT_W-1:0]   pol_rd;

  mod_ctl_t mod_ctl;
  mod_sts_t mod_sts;

  logic               accept;
  logic               explore_in;
  logic               is_choose;
  logic               is_update;
  logic               out_load;
  logic [STATE_W-1:0] scan_row;
  logic [ACT_W-1:0]   chosen_sel;

  assign accept     = req.valid && req.ready;
  assign req.ready  = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign explore_in = (req.explore_draw < explore_threshold);
  assign is_choose  = (op_r == OP_CHOOSE);
  assign is_update  = (op_r == OP_UPDATE);
  assign scan_row   = is_update ? ns_r : s_r;
  assign chosen_sel = explore_r ? mod_sts.rem : best_idx;
  assign out_load   = (state == ST_FINISH) && (!out_valid || rsp.ready);

  // Actions in use: 0 acts as 1, above the table width acts as full width
  always_comb begin
    if (action_count == '0) begin
      n_use = CNT_W'(1);
    end else if (action_count > CNT_W'(NUM_ACTIONS)) begin
      n_use = CNT_W'(NUM_ACTIONS);
    end else begin
      n_use = action_count;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate     <= LEARNING_RATE_RST;
      discount          <= DISCOUNT_RST;
      explore_threshold <= EXPLORE_THRESHOLD_RST;
      action_count      <= ACTION_COUNT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_LEARNING_RATE:     learning_rate     <= cfg.data;
        CFG_DISCOUNT:          discount          <= cfg.data;
        CFG_EXPLORE_THRESHOLD: explore_threshold <= cfg.data;
        CFG_ACTION_COUNT:      action_count      <= cfg.data[CNT_W-1:0];
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == QADDR_W'(Q_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req.operation == OP_CHOOSE) begin
            state_next = explore_in ? ST_MOD : ST_SCAN;
          end else if (req.operation == OP_UPDATE) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_RD_ISSUE;
          end
        end
      end
      ST_SCAN: begin
        if (CNT_W'(scan_i + CNT_W'(1)) == n_use) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_next = is_update ? ST_UP_MUL1 : ST_CH_POL;
      ST_MOD: begin
        if (mod_sts.done) begin
          state_next = ST_CH_RD;
        end
      end
      ST_CH_RD:    state_next = ST_CH_POL;
      ST_CH_POL:   state_next = ST_FINISH;
      ST_UP_MUL1:  state_next = ST_UP_DIFF;
      ST_UP_DIFF:  state_next = ST_UP_MUL2;
      ST_UP_MUL2:  state_next = ST_UP_WB;
      ST_UP_WB:    state_next = ST_FINISH;
      ST_RD_ISSUE: state_next = ST_RD_DATA;
      ST_RD_DATA:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + QADDR_W'(1);
      end
    end
  end

  // Request capture and scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_i  <= '0;
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= (state == ST_SCAN);
      if (accept) begin
        scan_i <= '0;
      end else if (state == ST_SCAN) begin
        scan_i <= scan_i + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= req.operation;
      s_r       <= req.state_index;
      a_r       <= req.action_index;
      ns_r      <= req.next_state_index;
      reward_r  <= req.reward_value;
      explore_r <= (req.operation == OP_CHOOSE) && explore_in;
    end
    cmp_idx <= scan_i[ACT_W-1:0];
  end

  // Running maximum over the row; the first largest entry wins
  always_ff @(posedge clk) begin
    if (cmp_vld) begin
      if (cmp_idx == '0 || q_rd > best) begin
        best     <= q_rd;
        best_idx <= cmp_idx;
      end
    end
  end

  // Q memory port
  always_comb begin
    q_addr  = {s_r, a_r};
    q_we    = 1'b0;
    q_re    = 1'b0;
    q_wdata = nv_sat;
    unique case (state)
      ST_CLEAR: begin
        q_addr  = clr_cnt;
        q_we    = 1'b1;
        q_wdata = '0;
      end
      ST_SCAN: begin
        q_addr = {scan_row, scan_i[ACT_W-1:0]};
        q_re   = 1'b1;
      end
      ST_CH_RD: begin
        q_addr = {s_r, mod_sts.rem};
        q_re   = 1'b1;
      end
      ST_UP_MUL1, ST_RD_ISSUE: q_re = 1'b1;
      ST_UP_WB:                q_we = 1'b1;
      default: begin
      end
    endcase
  end

  // Policy memory port; read once at accept, held for the item
  always_comb begin
    p_addr  = s_r;
    p_we    = 1'b0;
    p_re    = 1'b0;
    p_wdata = chosen_sel;
    unique case (state)
      ST_CLEAR: begin
        p_addr  = clr_cnt[STATE_W-1:0];
        p_we    = 1'b1;
        p_wdata = '0;
      end
      ST_IDLE: begin
        p_addr = req.state_index;
        p_re   = accept;
      end
      ST_CH_POL: p_we = 1'b1;
      default: begin
      end
    endcase
  end

  qltu_ram #(.WIDTH(Q_W), .DEPTH(Q_DEPTH)) u_q_ram (
    .clk   (clk),
    .we    (q_we),
    .re    (q_re),
    .addr  (q_addr),
    .wdata (q_wdata),
    .rdata (q_rd)
  );

  qltu_ram #(.WIDTH(ACT_W), .DEPTH(NUM_STATES)) u_pol_ram (
    .clk   (clk),
    .we    (p_we),
    .re    (p_re),
    .addr  (p_addr),
    .wdata (p_wdata),
    .rdata (pol_rd)
  );

  // Explore action: random word modulo actions in use
  assign mod_ctl.start = accept && (req.operation == OP_CHOOSE) && explore_in;
  assign mod_ctl.word  = req.random_word;
  assign mod_ctl.count = n_use;

  qltu_mod u_mod (
    .clk (clk),
    .rst (rst),
    .ctl (mod_ctl),
    .sts (mod_sts)
  );

  // Shared multiplier: gamma * max first, then alpha * difference
  assign mul_coef = (state == ST_UP_MUL2) ? learning_rate : discount;
  assign mul_opnd = (state == ST_UP_MUL2) ? diff : diff_t'(best);

  qltu_mul u_mul (
    .clk  (clk),
    .coef (mul_coef),
    .opnd (mul_opnd),
    .prod (prod)
  );

  // Arithmetic shift right by 16 is the floor of the scaled product
  assign g       = prod[Q_W+FRAC_W-1:FRAC_W];
  assign inc     = prod[PROD_W-1:FRAC_W];
  assign nv_wide = nv_t'(cur) + nv_t'(inc);

  // Saturate the new value to 32 bits
  always_comb begin
    nv_sat   = nv_wide[Q_W-1:0];
    sat_flag = 1'b0;
    if (nv_wide > nv_t'(Q_MAX)) begin
      nv_sat   = Q_MAX;
      sat_flag = 1'b1;
    end else if (nv_wide < nv_t'(Q_MIN)) begin
      nv_sat   = Q_MIN;
      sat_flag = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UP_DIFF) begin
      cur  <= q_rd;
      diff <= diff_t'(reward_r) + diff_t'(g) - diff_t'(q_rd);
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_CH_POL: begin
        res_chosen <= chosen_sel;
        res_q      <= explore_r ? q_rd : best;
        res_sat    <= 1'b0;
      end
      ST_UP_WB: begin
        res_chosen <= a_r;
        res_q      <= nv_sat;
        res_sat    <= sat_flag;
      end
      ST_RD_DATA: begin
        res_chosen <= a_r;
        res_q      <= q_rd;
        res_sat    <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chosen <= res_chosen;
      out_q      <= res_q;
      out_pol    <= is_choose ? res_chosen : pol_rd;
      out_sat    <= res_sat;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.chosen_action = out_chosen;
  assign rsp.q_value       = out_q;
  assign rsp.policy_action = out_pol;
  assign rsp.saturated     = out_sat;

endmodule
